FILE: sv/rtc_date_to_epoch_seconds_top_defines.svh
// ----------------------------------------------------------------------------
// RTC date to epoch seconds: assertion macros
// Shared property forms for the datapath checks, clocked on clock and
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef RTC_DATE_TO_EPOCH_SECONDS_TOP_DEFINES_SVH
`define RTC_DATE_TO_EPOCH_SECONDS_TOP_DEFINES_SVH

// same-cycle implication
`define RTCDE_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RTCDE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/rtcde_pkg.sv
// ----------------------------------------------------------------------------
// RTC date to epoch seconds: package
// Shared constants, the decoded date record and the BCD byte decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rtcde_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned YEAR_W   = 12;
   localparam int unsigned EPOCH_W  = 32;

   localparam logic [YEAR_W-1:0] YEAR_BASE   = 12'd1900;
   localparam logic [YEAR_W-1:0] EPOCH_YEAR  = 12'd1970;
   localparam logic [YEAR_W-1:0] CENTURY     = 12'd100;
   localparam logic [BYTE_W-1:0] FEB_MONTH   = 8'd2;
   localparam logic [BYTE_W-1:0] MONTH_WRAP  = 8'd10;

   localparam logic [8:0]         DAYS_YEAR   = 9'd365;
   localparam logic [8:0]         MONTH_MUL   = 9'd367;
   localparam logic [EPOCH_W-1:0] DAY_OFFSET  = 32'd719499;

   // x / 25 = (x * 656) >> 14, exact for x below 1024
   localparam logic [9:0]  RECIP25     = 10'd656;
   localparam int unsigned RECIP25_SH  = 14;
   // x / 3 = (x * 43691) >> 17, exact for x below 131072
   localparam logic [15:0] RECIP3      = 16'd43691;
   localparam int unsigned RECIP3_SH   = 17;

   localparam logic BCD_RESET = 1'b1;

   typedef struct packed {
      logic [BYTE_W-1:0] sec;
      logic [BYTE_W-1:0] min;
      logic [BYTE_W-1:0] hour;
      logic [BYTE_W-1:0] day;
      logic [BYTE_W-1:0] mon;
      logic [YEAR_W-1:0] year;
   } date_type;

   function automatic logic [BYTE_W-1:0] bcd_decode(input logic [BYTE_W-1:0] raw,
                                                    input logic bcd);
      logic [BYTE_W-1:0] hi;
      logic [BYTE_W-1:0] lo;
      hi = {4'b0000, raw[7:4]};
      lo = {4'b0000, raw[3:0]};
      if (bcd) begin
         return (hi << 3) + (hi << 1) + lo;
      end else begin
         return raw;
      end
   endfunction

endpackage

`default_nettype wire

FILE: sv/rtcde_calc.sv
// ----------------------------------------------------------------------------
// RTC date to epoch seconds: day count and seconds pipeline
// Six register stages from a decoded date to 32-bit epoch seconds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "rtc_date_to_epoch_seconds_top_defines.svh"

module rtcde_calc (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   input  wire rtcde_pkg::date_type    in_date,
   output logic                        out_valid,
   output logic [31:0]                 out_epoch
);
   import rtcde_pkg::*;

   // stage 2: products
   logic        v2_ff, v2_in;
   logic [9:0]  y4_ff;
   logic [19:0] p100_ff;
   logic [17:0] p400_ff;
   logic [19:0] y365_ff;
   logic [16:0] m367_ff;
   logic [7:0]  day2_ff, hour2_ff, min2_ff, sec2_ff;

   // stage 3: partial day count, month quotient product
   logic        v3_ff;
   logic [31:0] part_ff, part_in;
   logic [30:0] mqp_ff, mqp_in;
   logic [16:0] m367_3_ff;
   logic [7:0]  hour3_ff, min3_ff, sec3_ff;
   logic [5:0]  q100;
   logic [3:0]  q400;

   // stage 4: days
   logic        v4_ff;
   logic [31:0] days_ff, days_in;
   logic [12:0] mq;
   logic [7:0]  hour4_ff, min4_ff, sec4_ff;

   // stages 5 to 7
   logic        v5_ff, v6_ff, v7_ff;
   logic [31:0] hrs_ff, hrs_in, mins_ff, mins_in, secs_ff, secs_in;
   logic [7:0]  min5_ff, sec5_ff, sec6_ff;

   assign v2_in = in_valid;

   assign q100    = p100_ff[19:RECIP25_SH];
   assign q400    = p400_ff[17:RECIP25_SH];
   assign mqp_in  = 31'(m367_ff[16:2]) * 31'(RECIP3);
   assign part_in = 32'(y4_ff) - 32'(q100) + 32'(q400) + 32'(day2_ff)
                  + 32'(y365_ff) - DAY_OFFSET;

   assign mq      = mqp_ff[29:RECIP3_SH];
   assign days_in = part_ff + 32'(mq);

   assign hrs_in  = (days_ff << 4) + (days_ff << 3) + 32'(hour4_ff);
   assign mins_in = (hrs_ff << 6) - (hrs_ff << 2) + 32'(min5_ff);
   assign secs_in = (mins_ff << 6) - (mins_ff << 2) + 32'(sec6_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else begin
         v2_ff <= v2_in;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      y4_ff     <= in_date.year[11:2];
      p100_ff   <= 20'(in_date.year[11:2]) * 20'(RECIP25);
      p400_ff   <= 18'(in_date.year[11:4]) * 18'(RECIP25);
      y365_ff   <= 20'(in_date.year) * 20'(DAYS_YEAR);
      m367_ff   <= 17'(in_date.mon) * 17'(MONTH_MUL);
      day2_ff   <= in_date.day;
      hour2_ff  <= in_date.hour;
      min2_ff   <= in_date.min;
      sec2_ff   <= in_date.sec;

      part_ff   <= part_in;
      mqp_ff    <= mqp_in;
      m367_3_ff <= m367_ff;
      hour3_ff  <= hour2_ff;
      min3_ff   <= min2_ff;
      sec3_ff   <= sec2_ff;

      days_ff   <= days_in;
      hour4_ff  <= hour3_ff;
      min4_ff   <= min3_ff;
      sec4_ff   <= sec3_ff;

      hrs_ff    <= hrs_in;
      min5_ff   <= min4_ff;
      sec5_ff   <= sec4_ff;

      mins_ff   <= mins_in;
      sec6_ff   <= sec5_ff;

      secs_ff   <= secs_in;
   end

   assign out_valid = v7_ff;
   assign out_epoch = secs_ff;

   `RTCDE_ASSERT_NEXT(a_latency, in_valid, ##5 v7_ff, "transaction lost in pipeline")
   `RTCDE_ASSERT_NOW(a_century_quot, v2_ff,
      (11'(q100) * 11'd25 <= 11'(y4_ff)) && (11'(y4_ff) < 11'(q100) * 11'd25 + 11'd25),
      "year per century quotient wrong")
   `RTCDE_ASSERT_NOW(a_month_quot, v3_ff,
      (17'(mq) * 17'd12 <= m367_3_ff) && (m367_3_ff < 17'(mq) * 17'd12 + 17'd12),
      "month day quotient wrong")

endmodule

`default_nettype wire

FILE: sv/rtc_date_to_epoch_seconds_top.sv
// ----------------------------------------------------------------------------
// RTC date to epoch seconds: top level
// Decodes raw RTC register bytes and converts them to seconds since 1970.
// ----------------------------------------------------------------------------
// channel   | ports                         | handshake
// request   | start, busy, req_*_raw        | taken when start and not busy
// response  | rsp_valid, rsp_epoch_seconds  | one-cycle strobe, no back-pressure
// config    | csr_valid, csr_ready, csr_wdata | written when valid and ready
//
// Seven register stages; one transaction per cycle.
// The pipeline ends in the multiply chain days*24, *60, *60.
// busy stays low; csr_ready stays high.
// Synchronous reset clears the valid pipeline and sets bcd_mode to 1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rtc_date_to_epoch_seconds_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [7:0]  req_second_raw,
   input  wire logic [7:0]  req_minute_raw,
   input  wire logic [7:0]  req_hour_raw,
   input  wire logic [7:0]  req_day_raw,
   input  wire logic [7:0]  req_month_raw,
   input  wire logic [7:0]  req_year_raw,
   output logic             rsp_valid,
   output logic [31:0]      rsp_epoch_seconds,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_wdata
);
   import rtcde_pkg::*;

   logic     bcd_ff, bcd_in;
   logic     v1_ff, v1_in;
   date_type date_ff, date_in;

   logic [BYTE_W-1:0] mon_dec, yr_dec;
   logic [YEAR_W-1:0] yr_full, yr_adj;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   assign bcd_in = (csr_valid && csr_ready) ? csr_wdata : bcd_ff;
   assign v1_in  = start && !busy;

   always_comb begin
      mon_dec      = bcd_decode(req_month_raw, bcd_ff);
      yr_dec       = bcd_decode(req_year_raw, bcd_ff);
      yr_full      = YEAR_W'(yr_dec) + YEAR_BASE;
      yr_adj       = (yr_full < EPOCH_YEAR) ? yr_full + CENTURY : yr_full;
      date_in.sec  = bcd_decode(req_second_raw, bcd_ff);
      date_in.min  = bcd_decode(req_minute_raw, bcd_ff);
      date_in.hour = bcd_decode(req_hour_raw, bcd_ff);
      date_in.day  = bcd_decode(req_day_raw, bcd_ff);
      // March-first numbering
      if (mon_dec <= FEB_MONTH) begin
         date_in.mon  = mon_dec + MONTH_WRAP;
         date_in.year = yr_adj - 12'd1;
      end else begin
         date_in.mon  = mon_dec - FEB_MONTH;
         date_in.year = yr_adj;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bcd_ff <= BCD_RESET;
         v1_ff  <= 1'b0;
      end else begin
         bcd_ff <= bcd_in;
         v1_ff  <= v1_in;
      end
   end

   always_ff @(posedge clock) begin
      date_ff <= date_in;
   end

   rtcde_calc u_calc (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v1_ff),
      .in_date   (date_ff),
      .out_valid (rsp_valid),
      .out_epoch (rsp_epoch_seconds)
   );

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// Testbench for RTC date to epoch seconds
// Sends RTC register snapshots through the start/busy port and checks each
// epoch_seconds strobe against a known value or a calendar predictor kept in the bench.
// The run covers BCD and binary modes, extremes, malformed bytes and random
// traffic with idle bursts on the request side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

   import rtcde_pkg::*;

   localparam int unsigned RANDOM_PHASES = 6;
   localparam int unsigned PHASE_ITEMS   = 100;

   typedef struct packed {
      logic [BYTE_W-1:0] sec;
      logic [BYTE_W-1:0] minute;
      logic [BYTE_W-1:0] hour;
      logic [BYTE_W-1:0] day;
      logic [BYTE_W-1:0] month;
      logic [BYTE_W-1:0] year;
   } rtc_snapshot_type;

   typedef struct packed {
      logic               bcd;
      rtc_snapshot_type   regs;
      logic               known;
      logic [EPOCH_W-1:0] epoch;
   } directed_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [BYTE_W-1:0] req_second_raw = '0;
   logic [BYTE_W-1:0] req_minute_raw = '0;
   logic [BYTE_W-1:0] req_hour_raw   = '0;
   logic [BYTE_W-1:0] req_day_raw    = '0;
   logic [BYTE_W-1:0] req_month_raw  = '0;
   logic [BYTE_W-1:0] req_year_raw   = '0;
   logic              rsp_valid;
   logic [31:0]       rsp_epoch_seconds;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic              csr_wdata = 1'b0;

   logic [EPOCH_W-1:0] expected_epochs[$];
   logic [EPOCH_W-1:0] due_epoch;
   logic               bcd_mode_shadow = BCD_RESET;
   int unsigned        mismatches = 0;

   rtc_date_to_epoch_seconds_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_second_raw    (req_second_raw),
      .req_minute_raw    (req_minute_raw),
      .req_hour_raw      (req_hour_raw),
      .req_day_raw       (req_day_raw),
      .req_month_raw     (req_month_raw),
      .req_year_raw      (req_year_raw),
      .rsp_valid         (rsp_valid),
      .rsp_epoch_seconds (rsp_epoch_seconds),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tb_top failed");
      $finish;
   end

   function automatic logic [31:0] register_value(input logic [BYTE_W-1:0] b, input logic bcd);
      if (bcd) begin
         return {28'd0, b[3:0]} + {28'd0, b[7:4]} * 32'd10;
      end else begin
         return {24'd0, b};
      end
   endfunction

   // day count with March as first month, all arithmetic mod 2^32
   function automatic logic [EPOCH_W-1:0] calendar_to_epoch(input rtc_snapshot_type s,
                                                            input logic bcd);
      logic [31:0] sec;
      logic [31:0] minute;
      logic [31:0] hour;
      logic [31:0] day;
      logic [31:0] month;
      logic [31:0] year;
      logic [31:0] t;
      sec    = register_value(s.sec, bcd);
      minute = register_value(s.minute, bcd);
      hour   = register_value(s.hour, bcd);
      day    = register_value(s.day, bcd);
      month  = register_value(s.month, bcd);
      year   = register_value(s.year, bcd) + 32'd1900;
      if (year < 32'd1970) begin
         year = year + 32'd100;
      end
      if (month <= 32'd2) begin
         month = month + 32'd10;
         year  = year - 32'd1;
      end else begin
         month = month - 32'd2;
      end
      t = year / 32'd4 - year / 32'd100 + year / 32'd400 + (32'd367 * month) / 32'd12 + day;
      t = t + year * 32'd365 - 32'd719499;
      t = t * 32'd24 + hour;
      t = t * 32'd60 + minute;
      t = t * 32'd60 + sec;
      return t;
   endfunction

   function automatic logic [BYTE_W-1:0] to_bcd(input int unsigned v);
      return {4'(v / 10), 4'(v % 10)};
   endfunction

   // mostly plausible dates, the rest arbitrary bytes
   function automatic rtc_snapshot_type random_snapshot(input logic bcd);
      rtc_snapshot_type s;
      int unsigned      f[6];
      if ($urandom_range(0, 9) < 7) begin
         f[0] = $urandom_range(0, 59);
         f[1] = $urandom_range(0, 59);
         f[2] = $urandom_range(0, 23);
         f[3] = $urandom_range(1, 31);
         f[4] = $urandom_range(1, 12);
         f[5] = bcd ? $urandom_range(0, 99) : $urandom_range(0, 206);
         if (bcd) begin
            s = {to_bcd(f[0]), to_bcd(f[1]), to_bcd(f[2]), to_bcd(f[3]), to_bcd(f[4]),
                 to_bcd(f[5])};
         end else begin
            s = {8'(f[0]), 8'(f[1]), 8'(f[2]), 8'(f[3]), 8'(f[4]), 8'(f[5])};
         end
      end else begin
         s = {8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              8'($urandom)};
      end
      return s;
   endfunction

   task automatic report_mismatch(input string what, input logic [EPOCH_W-1:0] want,
                                  input logic [EPOCH_W-1:0] got);
      mismatches++;
      $display("%0t mismatch %s: expected %0d got %0d", $time, what, want, got);
   endtask

   task automatic send_snapshot(input rtc_snapshot_type s, input logic known,
                                input logic [EPOCH_W-1:0] epoch);
      start          <= 1'b1;
      req_second_raw <= s.sec;
      req_minute_raw <= s.minute;
      req_hour_raw   <= s.hour;
      req_day_raw    <= s.day;
      req_month_raw  <= s.month;
      req_year_raw   <= s.year;
      do @(posedge clock); while (busy);
      expected_epochs.push_back(known ? epoch : calendar_to_epoch(s, bcd_mode_shadow));
   endtask

   // start low, junk on the request bytes
   task automatic hold_off(input int unsigned cycles);
      start          <= 1'b0;
      req_second_raw <= 8'($urandom);
      req_minute_raw <= 8'($urandom);
      req_hour_raw   <= 8'($urandom);
      req_day_raw    <= 8'($urandom);
      req_month_raw  <= 8'($urandom);
      req_year_raw   <= 8'($urandom);
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_until_drained();
      start <= 1'b0;
      while (expected_epochs.size() != 0) @(posedge clock);
   endtask

   task automatic write_bcd_mode(input logic mode);
      wait_until_drained();
      csr_valid <= 1'b1;
      csr_wdata <= mode;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      bcd_mode_shadow = mode;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_epochs.size() == 0) begin
            report_mismatch("unexpected transaction", '0, rsp_epoch_seconds);
         end else begin
            due_epoch = expected_epochs.pop_front();
            if (rsp_epoch_seconds !== due_epoch) begin
               report_mismatch("epoch_seconds", due_epoch, rsp_epoch_seconds);
            end
         end
      end
   end

   initial begin
      directed_row_type directed_rows[$];
      rtc_snapshot_type s;
      logic             mode;
      int unsigned      waited;

      // bcd, sec, min, hour, day, month, year, known, epoch
      directed_rows.push_back({1'b1, 48'h00_00_00_01_01_70, 1'b1, 32'd0});
      directed_rows.push_back({1'b1, 48'h00_00_00_01_01_00, 1'b1, 32'd946684800});
      directed_rows.push_back({1'b1, 48'h59_59_23_31_12_99, 1'b1, 32'd946684799});
      directed_rows.push_back({1'b1, 48'h07_14_03_19_01_38, 1'b1, 32'd2147483647});
      directed_rows.push_back({1'b1, 48'h08_14_03_19_01_38, 1'b1, 32'd2147483648});
      directed_rows.push_back({1'b1, 48'h00_00_00_00_00_00, 1'b0, 32'd0});
      directed_rows.push_back({1'b1, 48'hff_ff_ff_ff_ff_ff, 1'b0, 32'd0});
      directed_rows.push_back({1'b1, 48'h00_00_12_29_02_00, 1'b0, 32'd0});
      directed_rows.push_back({1'b1, 48'h30_30_12_15_13_99, 1'b0, 32'd0});
      directed_rows.push_back({1'b1, 48'haa_bb_cc_dd_ee_69, 1'b0, 32'd0});
      directed_rows.push_back({1'b1, 48'h59_59_23_31_12_69, 1'b0, 32'd0});
      directed_rows.push_back({1'b0, 48'h00_00_00_01_01_46, 1'b1, 32'd0});
      directed_rows.push_back({1'b0, 48'h00_00_00_01_01_00, 1'b1, 32'd946684800});
      directed_rows.push_back({1'b0, 48'h0f_1c_06_07_02_ce, 1'b1, 32'hffff_ffff});
      directed_rows.push_back({1'b0, 48'h10_1c_06_07_02_ce, 1'b1, 32'd0});
      directed_rows.push_back({1'b0, 48'hff_ff_ff_ff_ff_ff, 1'b0, 32'd0});
      directed_rows.push_back({1'b0, 48'h00_00_00_00_00_00, 1'b0, 32'd0});
      directed_rows.push_back({1'b0, 48'h3b_3b_17_1f_0c_45, 1'b0, 32'd0});
      directed_rows.push_back({1'b1, 48'h55_55_55_55_55_55, 1'b0, 32'd0});
      directed_rows.push_back({1'b1, 48'h00_00_00_01_03_70, 1'b0, 32'd0});
      directed_rows.push_back({1'b1, 48'h99_99_99_99_99_99, 1'b0, 32'd0});

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      write_bcd_mode(1'b1);
      foreach (directed_rows[i]) begin
         if (directed_rows[i].bcd != bcd_mode_shadow) begin
            write_bcd_mode(directed_rows[i].bcd);
         end
         send_snapshot(directed_rows[i].regs, directed_rows[i].known, directed_rows[i].epoch);
         if ($urandom_range(0, 3) == 0) begin
            hold_off($urandom_range(1, 17));
         end
      end

      // modes alternate per phase; phases 3 and 5 run back to back
      for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
         mode = phase[0];
         write_bcd_mode(mode);
         for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
            s = random_snapshot(mode);
            send_snapshot(s, 1'b0, '0);
            if (phase == 1 && n == PHASE_ITEMS / 2) begin
               wait_until_drained();
            end else if (phase != 3 && phase != 5 && $urandom_range(0, 6) == 0) begin
               hold_off($urandom_range(1, 17));
            end
         end
      end

      start <= 1'b0;
      waited = 0;
      while (expected_epochs.size() != 0 && waited < 1000) begin
         @(posedge clock);
         waited++;
      end
      while (expected_epochs.size() != 0) begin
         report_mismatch("missing transaction", expected_epochs.pop_front(), '0);
      end
      repeat (16) @(posedge clock);

      if (mismatches == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
